### rtl/bffl_pkg.sv
// Shared types and codes for the best-fit free-list allocator.
// No dependencies; used by the compare unit and the top level.
`default_nettype none

package bffl_pkg;

  localparam int LEN_W  = 32;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP  = 2'd2;

  localparam logic ANS_ALLOC = 1'b0;
  localparam logic ANS_DUMP  = 1'b1;

  typedef struct packed {
    logic             fits;   // a >= b
    logic             less;   // a < c
    logic             zero;   // a == b
    logic [LEN_W-1:0] diff;   // a - b
  } cmp_res_t;

endpackage

`default_nettype wire

### rtl/bffl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bffl_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/bffl_cmp_unit.sv
// Shared length compare/subtract unit of the allocator.
// Depends on bffl_pkg for the result struct.
`default_nettype none

module bffl_cmp_unit (
  input  wire logic [bffl_pkg::LEN_W-1:0] a,
  input  wire logic [bffl_pkg::LEN_W-1:0] b,
  input  wire logic [bffl_pkg::LEN_W-1:0] c,
  output bffl_pkg::cmp_res_t              res
);
  import bffl_pkg::*;

  logic [LEN_W:0] diff_ext;

  assign diff_ext  = {1'b0, a} - {1'b0, b};
  assign res.fits  = ~diff_ext[LEN_W];
  assign res.diff  = diff_ext[LEN_W-1:0];
  assign res.zero  = (diff_ext == '0);
  assign res.less  = (a < c);

endmodule

`default_nettype wire

### rtl/best_fit_free_list_allocator_top.sv
// Best-fit free-list allocator: sequencer, table RAM and shared compare unit.
// Depends on bffl_pkg, bffl_ram and bffl_cmp_unit.
//
// The free table lives in one RAM word per slot {valid, start, length}; a slot
// counts as valid only below the load count, so no clearing pass is needed after
// reset. A load is written straight into the next slot. An allocate walks all
// ENTRIES slots from the rover through the RAM's single read port, one slot per
// cycle; an exact fit adds a second walk from the slot after the freed one to
// find the next valid slot for the rover. A dump walks the table once. A new
// result waits while the result channel still holds the previous one.
// No new item is taken until the current one finishes.
`default_nettype none

module best_fit_free_list_allocator_top #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bffl_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [31:0]                   in_block_start,
  input  wire logic [bffl_pkg::LEN_W-1:0]    in_block_length,
  input  wire logic [bffl_pkg::LEN_W-1:0]    in_request_size,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_answer_kind,
  output logic                               out_granted,
  output logic [31:0]                        out_start,
  output logic [bffl_pkg::LEN_W-1:0]         out_length,
  output logic                               out_last
);
  import bffl_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = ADDR_BITS;
  localparam int WW = 1 + AW + LEN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASCAN = 3'd1;
  localparam logic [2:0] S_AFIN  = 3'd2;
  localparam logic [2:0] S_NSCAN = 3'd3;
  localparam logic [2:0] S_DSCAN = 3'd4;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    return (v == IW'(ENTRIES - 1)) ? '0 : v + 1'b1;
  endfunction

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    rover_r, rover_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    step_r, step_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic             found_r, found_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic [IW-1:0]    best_idx_r, best_idx_nxt;
  logic [LEN_W-1:0] best_len_r, best_len_nxt;
  logic [AW-1:0]    best_start_r, best_start_nxt;
  logic [LEN_W-1:0] need_r, need_nxt;
  logic [AW-1:0]    pend_start_r, pend_start_nxt;
  logic [LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic             out_granted_r, out_granted_nxt;
  logic [31:0]      out_start_r, out_start_nxt;
  logic [LEN_W-1:0] out_length_r, out_length_nxt;
  logic             out_last_r, out_last_nxt;

  // RAM port
  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [WW-1:0]    ram_wdata, ram_rdata;

  logic             rd_valid_bit;
  logic [AW-1:0]    rd_start;
  logic [LEN_W-1:0] rd_len;
  logic             entry_ok;

  logic [LEN_W-1:0] cmp_a;
  cmp_res_t         cmp_res;

  logic             slot_free, out_load, issue, take_rd;
  logic [63:0]      best_start_ext, pend_start_ext;

  assign rd_valid_bit   = ram_rdata[WW-1];
  assign rd_start       = ram_rdata[LEN_W +: AW];
  assign rd_len         = ram_rdata[LEN_W-1:0];
  assign entry_ok       = rd_ok_r & rd_valid_bit;
  assign best_start_ext = 64'(best_start_r);
  assign pend_start_ext = 64'(pend_start_r);
  assign slot_free      = ~out_valid_r | out_ready;
  assign cmp_a          = (state_r == S_AFIN) ? best_len_r : rd_len;

  bffl_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bffl_cmp_unit u_cmp (
    .a   (cmp_a),
    .b   (need_r),
    .c   (best_len_r),
    .res (cmp_res)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rover_nxt       = rover_r;
    idx_nxt         = idx_r;
    step_nxt        = step_r;
    found_nxt       = found_r;
    pend_v_nxt      = pend_v_r;
    rd_idx_nxt      = rd_idx_r;
    rd_ok_nxt       = rd_ok_r;
    best_idx_nxt    = best_idx_r;
    best_len_nxt    = best_len_r;
    best_start_nxt  = best_start_r;
    need_nxt        = need_r;
    pend_start_nxt  = pend_start_r;
    pend_len_nxt    = pend_len_r;
    out_kind_nxt    = out_kind_r;
    out_granted_nxt = out_granted_r;
    out_start_nxt   = out_start_r;
    out_length_nxt  = out_length_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = count_r[IW-1:0];
    ram_wdata       = {1'b1, AW'(in_block_start), in_block_length};
    ram_re          = 1'b0;
    ram_raddr       = idx_r;
    out_load        = 1'b0;
    issue           = 1'b0;
    take_rd         = 1'b0;
    in_ready        = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_LOAD: begin
              // drop loads once every slot has been used
              if (count_r < CW'(ENTRIES)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            KIND_ALLOC: begin
              need_nxt  = in_request_size;
              idx_nxt   = rover_r;
              step_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = S_ASCAN;
            end
            KIND_DUMP: begin
              idx_nxt    = rover_r;
              step_nxt   = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_DSCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_ASCAN: begin
        take_rd = rd_v_r;
        if (take_rd && entry_ok && cmp_res.fits && (!found_r || cmp_res.less)) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = rd_idx_r;
          best_len_nxt   = rd_len;
          best_start_nxt = rd_start;
        end
        issue = (step_r < CW'(ENTRIES));
        if (!issue && !rd_v_r) begin
          state_nxt = S_AFIN;
        end
      end

      S_AFIN: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_kind_nxt = ANS_ALLOC;
          out_last_nxt = 1'b1;
          if (!found_r) begin
            out_granted_nxt = 1'b0;
            out_start_nxt   = '0;
            out_length_nxt  = '0;
            state_nxt       = S_IDLE;
          end else begin
            out_granted_nxt = 1'b1;
            out_start_nxt   = best_start_ext[31:0];
            out_length_nxt  = cmp_res.diff;
            ram_we          = 1'b1;
            ram_waddr       = best_idx_r;
            if (cmp_res.zero) begin
              // free the slot, then look for the next valid one
              ram_wdata = {1'b0, best_start_r, best_len_r};
              idx_nxt   = wrap_inc(best_idx_r);
              step_nxt  = CW'(1);
              found_nxt = 1'b0;
              state_nxt = S_NSCAN;
            end else begin
              ram_wdata = {1'b1, best_start_r + AW'(need_r), cmp_res.diff};
              rover_nxt = best_idx_r;
              state_nxt = S_IDLE;
            end
          end
        end
      end

      S_NSCAN: begin
        take_rd = rd_v_r;
        if (take_rd && entry_ok && !found_r) begin
          found_nxt = 1'b1;
          rover_nxt = rd_idx_r;
        end
        issue = (step_r < CW'(ENTRIES));
        if (!issue && !rd_v_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_DSCAN: begin
        // an entry that must push out the pending one waits for the output slot
        take_rd = rd_v_r && (!(entry_ok && pend_v_r) || slot_free);
        if (take_rd && entry_ok) begin
          if (pend_v_r) begin
            out_load        = 1'b1;
            out_kind_nxt    = ANS_DUMP;
            out_granted_nxt = 1'b0;
            out_start_nxt   = pend_start_ext[31:0];
            out_length_nxt  = pend_len_r;
            out_last_nxt    = 1'b0;
          end
          pend_v_nxt     = 1'b1;
          pend_start_nxt = rd_start;
          pend_len_nxt   = rd_len;
        end
        issue = (step_r < CW'(ENTRIES)) && (!rd_v_r || take_rd);
        if ((step_r == CW'(ENTRIES)) && !rd_v_r) begin
          if (!pend_v_r) begin
            state_nxt = S_IDLE;
          end else if (slot_free) begin
            out_load        = 1'b1;
            out_kind_nxt    = ANS_DUMP;
            out_granted_nxt = 1'b0;
            out_start_nxt   = pend_start_ext[31:0];
            out_length_nxt  = pend_len_r;
            out_last_nxt    = 1'b1;
            pend_v_nxt      = 1'b0;
            state_nxt       = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // shared read issue: advance the circular index and tag the data
    if (issue) begin
      ram_re     = 1'b1;
      ram_raddr  = idx_r;
      idx_nxt    = wrap_inc(idx_r);
      step_nxt   = step_r + 1'b1;
      rd_idx_nxt = idx_r;
      rd_ok_nxt  = (CW'(idx_r) < count_r);
    end
    if (issue) begin
      rd_v_nxt = 1'b1;
    end else if (take_rd) begin
      rd_v_nxt = 1'b0;
    end else begin
      rd_v_nxt = rd_v_r;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rover_r     <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rover_r     <= rover_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    rd_ok_r       <= rd_ok_nxt;
    best_idx_r    <= best_idx_nxt;
    best_len_r    <= best_len_nxt;
    best_start_r  <= best_start_nxt;
    need_r        <= need_nxt;
    pend_start_r  <= pend_start_nxt;
    pend_len_r    <= pend_len_nxt;
    out_kind_r    <= out_kind_nxt;
    out_granted_r <= out_granted_nxt;
    out_start_r   <= out_start_nxt;
    out_length_r  <= out_length_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_answer_kind = out_kind_r;
  assign out_granted     = out_granted_r;
  assign out_start       = out_start_r;
  assign out_length      = out_length_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("load count beyond table size");

  a_rover_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rover_r <= IW'(ENTRIES - 1))
    else $error("rover outside table");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == S_ASCAN || state_r == S_NSCAN || state_r == S_DSCAN))
    else $error("read data pending outside a scan");

  a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AFIN && found_r) |-> (best_len_r >= need_r))
    else $error("chosen block shorter than request");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ASCAN && state_nxt == S_AFIN) |-> (step_r == CW'(ENTRIES)))
    else $error("allocate scan ended early");
`endif

endmodule

`default_nettype wire
